// File: rtl/swlf_pkg.sv
// ----------------------------------------------------------------------------
// swlf_pkg: shared types and codes for the sliding window line fit
// Holds item kind and status codes, fixed result field widths and the
// per-cell control group.
// ----------------------------------------------------------------------------
package swlf_pkg;

    // Item kinds on the input channel
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Status codes on the result channel
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Fixed result field widths
    localparam int COEF_A_W = 45;
    localparam int COEF_B_W = 43;
    localparam int COEF_C_W = 60;
    localparam int COUNT_W  = 7;

    // Control of one window cell
    typedef struct packed {
        logic shift;   // take the neighbor's point (pop)
        logic load;    // take the incoming point (push)
    } cell_ctrl_t;

endpackage

// File: rtl/swlf_cell.sv
// ----------------------------------------------------------------------------
// swlf_cell: one slot of the point window
// Holds one (x, y) point; shifts in its newer neighbor on a pop and loads the
// incoming point when it is the first free slot on a push.
// ----------------------------------------------------------------------------
module swlf_cell #(
    parameter int DATA_W = 32
) (
    input  logic                    aclk,
    input  swlf_pkg::cell_ctrl_t    ctrl,
    input  logic [DATA_W-1:0]       push_data,
    input  logic [DATA_W-1:0]       nbr_data,
    output logic [DATA_W-1:0]       cell_data
);

    logic [DATA_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            data_reg <= nbr_data;
        end else if (ctrl.load) begin
            data_reg <= push_data;
        end
    end

    assign cell_data = data_reg;

endmodule

// File: rtl/swlf_coef.sv
// ----------------------------------------------------------------------------
// swlf_coef: coefficient pipeline
// Forms the six products of the running sums in one stage and the three
// differences in the next, with a valid/ready handshake on each stage.
// ----------------------------------------------------------------------------
module swlf_coef #(
    parameter int SUM_X_W  = 23,
    parameter int SUM_XX_W = 38,
    parameter int SUM_XY_W = 38,
    parameter int CNT_W    = 7
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [SUM_X_W-1:0]               sum_x,
    input  logic signed [SUM_X_W-1:0]               sum_y,
    input  logic signed [SUM_XX_W-1:0]              sum_xx,
    input  logic signed [SUM_XY_W-1:0]              sum_xy,
    input  logic [CNT_W-1:0]                        count,
    input  logic [1:0]                              status,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [swlf_pkg::COEF_A_W-1:0]    coef_a,
    output logic signed [swlf_pkg::COEF_B_W-1:0]    coef_b,
    output logic signed [swlf_pkg::COEF_C_W-1:0]    coef_c,
    output logic [swlf_pkg::COUNT_W-1:0]            point_count,
    output logic                                    fit_valid,
    output logic [1:0]                              status_out
);

    localparam int AW = swlf_pkg::COEF_A_W;
    localparam int BW = swlf_pkg::COEF_B_W;
    localparam int CW = swlf_pkg::COEF_C_W;

    logic signed [CNT_W:0] n_s;

    // Product stage
    logic                 prod_valid_reg;
    logic signed [AW-1:0] n_sxy_reg, sy_sx_reg;
    logic signed [BW-1:0] sx_sx_reg, n_sxx_reg;
    logic signed [CW-1:0] sy_sxx_reg, sxy_sx_reg;
    logic [CNT_W-1:0]     prod_count_reg;
    logic [1:0]           prod_status_reg;

    // Result stage
    logic                            res_valid_reg;
    logic signed [AW-1:0]            coef_a_reg;
    logic signed [BW-1:0]            coef_b_reg;
    logic signed [CW-1:0]            coef_c_reg;
    logic [swlf_pkg::COUNT_W-1:0]    count_reg;
    logic                            fit_valid_reg;
    logic [1:0]                      status_reg;

    logic res_ready, prod_ready;

    assign res_ready  = !res_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || res_ready;
    assign in_ready   = prod_ready;

    assign n_s = $signed({1'b0, count});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_ready) begin
            prod_valid_reg <= in_valid;
        end
        if (in_valid && prod_ready) begin
            // products kept modulo the width of the field they feed
            n_sxy_reg       <= AW'(n_s) * AW'(sum_xy);
            sy_sx_reg       <= AW'(sum_y) * AW'(sum_x);
            sx_sx_reg       <= BW'(sum_x) * BW'(sum_x);
            n_sxx_reg       <= BW'(n_s) * BW'(sum_xx);
            sy_sxx_reg      <= CW'(sum_y) * CW'(sum_xx);
            sxy_sx_reg      <= CW'(sum_xy) * CW'(sum_x);
            prod_count_reg  <= count;
            prod_status_reg <= status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (res_ready) begin
            res_valid_reg <= prod_valid_reg;
        end
        if (prod_valid_reg && res_ready) begin
            coef_a_reg    <= n_sxy_reg - sy_sx_reg;
            coef_b_reg    <= sx_sx_reg - n_sxx_reg;
            coef_c_reg    <= sy_sxx_reg - sxy_sx_reg;
            count_reg     <= swlf_pkg::COUNT_W'(prod_count_reg);
            fit_valid_reg <= (prod_count_reg > CNT_W'(1));
            status_reg    <= prod_status_reg;
        end
    end

    assign out_valid   = res_valid_reg;
    assign coef_a      = coef_a_reg;
    assign coef_b      = coef_b_reg;
    assign coef_c      = coef_c_reg;
    assign point_count = count_reg;
    assign fit_valid   = fit_valid_reg;
    assign status_out  = status_reg;

endmodule

// File: rtl/sliding_window_line_fit.sv
// ----------------------------------------------------------------------------
// sliding_window_line_fit: least-squares line fit over a sliding point window
// Keeps a FIFO window of points with running sums and returns the line
// coefficients A, B, C after every command: push, pop, clear or unused kind.
// ----------------------------------------------------------------------------
// Usage: every transfer on the s_ channel is one command (push a point, pop
// the oldest point, clear the window) and yields exactly one transfer on the
// m_ channel with A = n*Sxy - Sy*Sx, B = Sx*Sx - n*Sxx, C = Sy*Sxx - Sxy*Sx,
// the point count n, fit_valid (n above one) and a status code for a push on
// a full window or a pop on an empty window, both of which leave the state
// untouched. The block takes one command per cycle while s_ready is high. Three
// register stages sit between the channels: the window and running sums
// update at the command's transfer, then the six sum products register and
// then the differences. A stalled m_ready holds the pipeline and, once all
// three stages are full, drops s_ready in the same cycle. The window is a
// row of WINDOW_DEPTH cells with the oldest point always in the first cell,
// so a pop reads it without addressing and shifts the row by one.
// Coefficients wrap to their field widths.
// ----------------------------------------------------------------------------
module sliding_window_line_fit #(
    parameter int WINDOW_DEPTH = 64,
    parameter int POINT_WIDTH  = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // command channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [1:0]                              s_kind,
    input  logic signed [POINT_WIDTH-1:0]           s_point_x,
    input  logic signed [POINT_WIDTH-1:0]           s_point_y,
    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [swlf_pkg::COEF_A_W-1:0]    m_coef_a,
    output logic signed [swlf_pkg::COEF_B_W-1:0]    m_coef_b,
    output logic signed [swlf_pkg::COEF_C_W-1:0]    m_coef_c,
    output logic [swlf_pkg::COUNT_W-1:0]            m_point_count,
    output logic                                    m_fit_valid,
    output logic [1:0]                              m_status
);

    localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int DEPTH_LW = $clog2(WINDOW_DEPTH);
    localparam int SUM_X_W  = POINT_WIDTH + DEPTH_LW + 1;
    localparam int SUM_XX_W = 2 * POINT_WIDTH + DEPTH_LW;
    localparam int SUM_XY_W = 2 * POINT_WIDTH + DEPTH_LW;
    localparam int DATA_W   = 2 * POINT_WIDTH;

    // Window state
    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [SUM_X_W-1:0]  sum_x_reg, sum_x_next;
    logic signed [SUM_X_W-1:0]  sum_y_reg, sum_y_next;
    logic signed [SUM_XX_W-1:0] sum_xx_reg, sum_xx_next;
    logic signed [SUM_XY_W-1:0] sum_xy_reg, sum_xy_next;

    // Sum snapshot handed to the coefficient pipeline
    logic       snap_valid_reg;
    logic [1:0] snap_status_reg, status_next;
    logic       coef_ready;

    logic accept, is_full, is_empty, push_ok, pop_ok;

    logic signed [POINT_WIDTH-1:0]     dx, dy;
    logic signed [2*POINT_WIDTH-1:0]   dxx, dxy;

    logic [DATA_W-1:0]                 push_data;
    logic [DATA_W-1:0]                 cell_data [WINDOW_DEPTH];
    swlf_pkg::cell_ctrl_t              cell_ctrl [WINDOW_DEPTH];

    // Accept a new command whenever the snapshot slot is free or moving on
    assign s_ready = !snap_valid_reg || coef_ready;
    assign accept  = s_valid && s_ready;

    assign is_full  = (count_reg == CNT_W'(WINDOW_DEPTH));
    assign is_empty = (count_reg == '0);
    assign push_ok  = accept && (s_kind == swlf_pkg::KIND_PUSH) && !is_full;
    assign pop_ok   = accept && (s_kind == swlf_pkg::KIND_POP) && !is_empty;

    // ------------------------------------------------------------------
    // Point window: row of cells, oldest point in cell 0
    // ------------------------------------------------------------------
    assign push_data = {s_point_x, s_point_y};

    for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] nbr;

        // Last cell shifts in don't-care data; the count marks it empty
        if (i == WINDOW_DEPTH - 1) begin : g_last
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = cell_data[i+1];
        end

        assign cell_ctrl[i].shift = pop_ok;
        assign cell_ctrl[i].load  = push_ok && (count_reg == CNT_W'(i));

        swlf_cell #(
            .DATA_W (DATA_W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[i]),
            .push_data (push_data),
            .nbr_data  (nbr),
            .cell_data (cell_data[i])
        );
    end

    // ------------------------------------------------------------------
    // Running sums: add the pushed point or subtract the popped one
    // ------------------------------------------------------------------
    always_comb begin
        if (s_kind == swlf_pkg::KIND_PUSH) begin
            dx = s_point_x;
            dy = s_point_y;
        end else begin
            dx = $signed(cell_data[0][DATA_W-1:POINT_WIDTH]);
            dy = $signed(cell_data[0][POINT_WIDTH-1:0]);
        end
        dxx = dx * dx;
        dxy = dx * dy;
    end

    always_comb begin
        count_next  = count_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        sum_xx_next = sum_xx_reg;
        sum_xy_next = sum_xy_reg;
        status_next = swlf_pkg::STATUS_OK;
        case (s_kind)
            swlf_pkg::KIND_PUSH: begin
                if (is_full) begin
                    status_next = swlf_pkg::STATUS_FULL;
                end else begin
                    count_next  = count_reg + CNT_W'(1);
                    sum_x_next  = sum_x_reg + SUM_X_W'(dx);
                    sum_y_next  = sum_y_reg + SUM_X_W'(dy);
                    sum_xx_next = sum_xx_reg + SUM_XX_W'(dxx);
                    sum_xy_next = sum_xy_reg + SUM_XY_W'(dxy);
                end
            end
            swlf_pkg::KIND_POP: begin
                if (is_empty) begin
                    status_next = swlf_pkg::STATUS_EMPTY;
                end else begin
                    count_next  = count_reg - CNT_W'(1);
                    sum_x_next  = sum_x_reg - SUM_X_W'(dx);
                    sum_y_next  = sum_y_reg - SUM_X_W'(dy);
                    sum_xx_next = sum_xx_reg - SUM_XX_W'(dxx);
                    sum_xy_next = sum_xy_reg - SUM_XY_W'(dxy);
                end
            end
            swlf_pkg::KIND_CLEAR: begin
                count_next  = '0;
                sum_x_next  = '0;
                sum_y_next  = '0;
                sum_xx_next = '0;
                sum_xy_next = '0;
            end
            default: begin
                // unused kind: no change, status ok
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            sum_xx_reg      <= '0;
            sum_xy_reg      <= '0;
            snap_valid_reg  <= 1'b0;
            snap_status_reg <= swlf_pkg::STATUS_OK;
        end else begin
            if (accept) begin
                count_reg       <= count_next;
                sum_x_reg       <= sum_x_next;
                sum_y_reg       <= sum_y_next;
                sum_xx_reg      <= sum_xx_next;
                sum_xy_reg      <= sum_xy_next;
                snap_status_reg <= status_next;
            end
            // hold the snapshot until the product stage takes it
            if (s_ready) begin
                snap_valid_reg <= accept;
            end
        end
    end

    // ------------------------------------------------------------------
    // Coefficients from the updated sums
    // ------------------------------------------------------------------
    swlf_coef #(
        .SUM_X_W  (SUM_X_W),
        .SUM_XX_W (SUM_XX_W),
        .SUM_XY_W (SUM_XY_W),
        .CNT_W    (CNT_W)
    ) u_coef (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (snap_valid_reg),
        .in_ready    (coef_ready),
        .sum_x       (sum_x_reg),
        .sum_y       (sum_y_reg),
        .sum_xx      (sum_xx_reg),
        .sum_xy      (sum_xy_reg),
        .count       (count_reg),
        .status      (snap_status_reg),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .coef_a      (m_coef_a),
        .coef_b      (m_coef_b),
        .coef_c      (m_coef_c),
        .point_count (m_point_count),
        .fit_valid   (m_fit_valid),
        .status_out  (m_status)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sliding_window_line_fit
// Drives push, pop, clear and unused-kind commands through the s_ channel,
// keeps its own window and running sums to form the expected A, B, C, count,
// valid flag and status, and compares every m_ transfer in order. Both
// channels idle and stall at random, with some quiet stretches in between.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WINDOW_DEPTH = 64;
    localparam int POINT_WIDTH  = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 600;
    localparam int FIT_SLOTS    = 64;

    // The fourth kind code has no name in the package; the block treats it
    // as a no-op with status OK.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef logic signed [POINT_WIDTH-1:0] coord_t;

    // One result transfer as the block should present it
    typedef struct {
        logic signed [swlf_pkg::COEF_A_W-1:0] coef_a;
        logic signed [swlf_pkg::COEF_B_W-1:0] coef_b;
        logic signed [swlf_pkg::COEF_C_W-1:0] coef_c;
        logic [swlf_pkg::COUNT_W-1:0]         point_count;
        logic                                 fit_valid;
        logic [1:0]                           status;
    } fit_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports; every input holds a known value from time 0
    // ------------------------------------------------------------------------
    logic                                  aclk      = 1'b0;
    logic                                  aresetn   = 1'b0;
    logic                                  s_valid   = 1'b0;
    logic                                  s_ready;
    logic [1:0]                            s_kind    = swlf_pkg::KIND_PUSH;
    coord_t                                s_point_x = '0;
    coord_t                                s_point_y = '0;
    logic                                  m_valid;
    logic                                  m_ready   = 1'b0;
    logic signed [swlf_pkg::COEF_A_W-1:0]  m_coef_a;
    logic signed [swlf_pkg::COEF_B_W-1:0]  m_coef_b;
    logic signed [swlf_pkg::COEF_C_W-1:0]  m_coef_c;
    logic [swlf_pkg::COUNT_W-1:0]          m_point_count;
    logic                                  m_fit_valid;
    logic [1:0]                            m_status;

    always #5 aclk = ~aclk;

    sliding_window_line_fit #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .POINT_WIDTH  (POINT_WIDTH)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coef_a      (m_coef_a),
        .m_coef_b      (m_coef_b),
        .m_coef_c      (m_coef_c),
        .m_point_count (m_point_count),
        .m_fit_valid   (m_fit_valid),
        .m_status      (m_status)
    );

    // ------------------------------------------------------------------------
    // Shadow of the window: points, oldest slot, fill level and running sums.
    // Sums wrap modulo 2^64; outputs are cut to their field widths afterwards,
    // where the block's coefficients wrap as well.
    // ------------------------------------------------------------------------
    coord_t      shadow_x [WINDOW_DEPTH];
    coord_t      shadow_y [WINDOW_DEPTH];
    int          oldest_slot = 0;
    int          held_points = 0;
    bit [63:0]   run_sx  = '0;
    bit [63:0]   run_sy  = '0;
    bit [63:0]   run_sxx = '0;
    bit [63:0]   run_sxy = '0;

    // Expected results in order: a ring indexed by running write/read counts
    fit_result_t expected_fits [FIT_SLOTS];
    int          fit_wr      = 0;
    int          fit_rd      = 0;
    int          fit_errors  = 0;
    int          cycle_count = 0;
    bit          quiet_mode  = 1'b0;
    int          stall_left  = 0;

    // Mostly short gaps, now and then a long one; none in a quiet stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Extremes, tiny values around zero, or anything in the full range.
    function automatic coord_t pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'sh7fff;
        if (r == 1) return 16'sh8000;
        if (r == 2) return coord_t'($urandom_range(0, 16) - 8);
        return coord_t'($urandom);
    endfunction

    // Add a point to the running sums, or take it back out on a pop.
    function automatic void move_sums(coord_t x, coord_t y, bit remove);
        bit [63:0] ux, uy;
        ux = {{(64-POINT_WIDTH){x[POINT_WIDTH-1]}}, x};
        uy = {{(64-POINT_WIDTH){y[POINT_WIDTH-1]}}, y};
        if (remove) begin
            run_sx  -= ux;
            run_sy  -= uy;
            run_sxx -= ux * ux;
            run_sxy -= ux * uy;
        end else begin
            run_sx  += ux;
            run_sy  += uy;
            run_sxx += ux * ux;
            run_sxy += ux * uy;
        end
    endfunction

    // Apply one accepted command to the shadow and queue the line fit it yields.
    function automatic void predict_fit(logic [1:0] kind, coord_t x, coord_t y);
        fit_result_t r;
        bit [63:0]   n, a, b, c;
        int          slot;
        r.status = swlf_pkg::STATUS_OK;
        case (kind)
            swlf_pkg::KIND_PUSH: begin
                if (held_points >= WINDOW_DEPTH) begin
                    r.status = swlf_pkg::STATUS_FULL;
                end else begin
                    slot = (oldest_slot + held_points) % WINDOW_DEPTH;
                    shadow_x[slot] = x;
                    shadow_y[slot] = y;
                    held_points++;
                    move_sums(x, y, 1'b0);
                end
            end
            swlf_pkg::KIND_POP: begin
                if (held_points == 0) begin
                    r.status = swlf_pkg::STATUS_EMPTY;
                end else begin
                    move_sums(shadow_x[oldest_slot], shadow_y[oldest_slot], 1'b1);
                    oldest_slot = (oldest_slot + 1) % WINDOW_DEPTH;
                    held_points--;
                end
            end
            swlf_pkg::KIND_CLEAR: begin
                oldest_slot = 0;
                held_points = 0;
                run_sx  = '0;
                run_sy  = '0;
                run_sxx = '0;
                run_sxy = '0;
            end
            default: ;
        endcase
        n = 64'(held_points);
        a = n * run_sxy - run_sy * run_sx;
        b = run_sx * run_sx - n * run_sxx;
        c = run_sy * run_sxx - run_sxy * run_sx;
        r.coef_a      = a[swlf_pkg::COEF_A_W-1:0];
        r.coef_b      = b[swlf_pkg::COEF_B_W-1:0];
        r.coef_c      = c[swlf_pkg::COEF_C_W-1:0];
        r.point_count = n[swlf_pkg::COUNT_W-1:0];
        r.fit_valid   = (held_points > 1);
        expected_fits[fit_wr % FIT_SLOTS] = r;
        fit_wr++;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: hold valid low for a random gap, present the command, then hold
    // it until the transfer. Valid stays high into the next call when that
    // call picks no gap, so it is never lowered and raised in one step.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] kind, input coord_t x, input coord_t y);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_point_x <= x;
        s_point_y <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_fit(kind, x, y);
    endtask

    // Drop valid and wait until every queued fit has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (fit_wr != fit_rd) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall m_ready for random stretches
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each result transfer with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        fit_result_t want;
        bit          missing;
        if (aresetn && m_valid && m_ready) begin
            missing = (fit_wr == fit_rd);
            if (!missing) begin
                want = expected_fits[fit_rd % FIT_SLOTS];
                fit_rd++;
            end
            if (missing
                || m_coef_a      !== want.coef_a
                || m_coef_b      !== want.coef_b
                || m_coef_c      !== want.coef_c
                || m_point_count !== want.point_count
                || m_fit_valid   !== want.fit_valid
                || m_status      !== want.status) begin
                if (fit_errors < 10) begin
                    if (missing)
                        $display("ERROR: unexpected result at cycle %0d", cycle_count);
                    else
                        $display("ERROR: cycle %0d expected A=%0d B=%0d C=%0d n=%0d v=%0b st=%0d",
                                 cycle_count, want.coef_a, want.coef_b, want.coef_c,
                                 want.point_count, want.fit_valid, want.status);
                    $display("       got A=%0d B=%0d C=%0d n=%0d v=%0b st=%0d",
                             m_coef_a, m_coef_b, m_coef_c, m_point_count,
                             m_fit_valid, m_status);
                end
                fit_errors++;
            end
        end
    end

    // Watchdog: end the run if the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Extremes of the coordinates, every kind, pop on empty, few-point fits.
    task automatic test_corner_points();
        send_item(swlf_pkg::KIND_POP,   16'sh0000, 16'sh0000);   // pop on empty window
        send_item(KIND_UNUSED,          16'shffff, 16'shffff);   // unused kind, all bits set
        send_item(swlf_pkg::KIND_PUSH,  16'sh7fff, 16'sh8000);   // one point: A and B zero
        send_item(swlf_pkg::KIND_PUSH,  16'sh8000, 16'sh7fff);
        send_item(swlf_pkg::KIND_PUSH,  16'sh0000, 16'sh0000);
        send_item(swlf_pkg::KIND_PUSH,  16'shffff, 16'shffff);
        send_item(swlf_pkg::KIND_PUSH,  16'sh0001, 16'sh0001);
        send_item(KIND_UNUSED,          16'sh0000, 16'sh0000);
        send_item(swlf_pkg::KIND_POP,   16'sh1234, 16'sh4321);
        send_item(swlf_pkg::KIND_POP,   16'sh0000, 16'sh0000);
        send_item(swlf_pkg::KIND_CLEAR, 16'sh7fff, 16'sh7fff);
        send_item(swlf_pkg::KIND_POP,   16'sh0000, 16'sh0000);   // empty again after clear
        send_item(swlf_pkg::KIND_PUSH,  16'sh8000, 16'sh8000);
        send_item(swlf_pkg::KIND_PUSH,  16'sh8000, 16'sh8000);   // same x twice: vertical line
        send_item(swlf_pkg::KIND_PUSH,  16'sh7fff, 16'sh7fff);
        send_item(swlf_pkg::KIND_CLEAR, 16'sh0000, 16'sh0000);
    endtask

    // Fill the window to the brim with extreme points, push on full, wrap the
    // oldest slot around, then empty it completely.
    task automatic test_full_window();
        int i;
        send_item(swlf_pkg::KIND_CLEAR, 16'sh0000, 16'sh0000);
        for (i = 0; i < WINDOW_DEPTH; i++)
            send_item(swlf_pkg::KIND_PUSH, 16'sh8000, 16'sh8000);
        send_item(swlf_pkg::KIND_PUSH, pick_coord(), pick_coord());
        for (i = 0; i < 10; i++)
            send_item(swlf_pkg::KIND_POP, pick_coord(), pick_coord());
        for (i = 0; i < 10; i++)
            send_item(swlf_pkg::KIND_PUSH, pick_coord(), pick_coord());
        send_item(swlf_pkg::KIND_PUSH, pick_coord(), pick_coord());
        for (i = 0; i <= WINDOW_DEPTH; i++)
            send_item(swlf_pkg::KIND_POP, pick_coord(), pick_coord());
        // alternate x extremes: B reaches its most negative value
        for (i = 0; i < WINDOW_DEPTH; i++)
            send_item(swlf_pkg::KIND_PUSH, i[0] ? 16'sh7fff : 16'sh8000, pick_coord());
        send_item(swlf_pkg::KIND_PUSH, 16'sh7fff, 16'sh7fff);
        send_item(swlf_pkg::KIND_CLEAR, 16'sh0000, 16'sh0000);
    endtask

    // Pause the sender until the block has returned every result.
    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 20; i++)
            send_item(swlf_pkg::KIND_PUSH, pick_coord(), pick_coord());
        wait_drained();
        repeat (5) @(posedge aclk);
        for (i = 0; i < 20; i++)
            send_item($urandom_range(0, 3) == 0 ? swlf_pkg::KIND_POP : swlf_pkg::KIND_PUSH,
                      pick_coord(), pick_coord());
    endtask

    // Random walk of the fill level: each phase picks a push bias so the
    // window drifts toward full or empty; a few clears and unused kinds mixed in.
    task automatic test_random_walk(input int item_total);
        int         sent, phase_len, push_pct, r;
        logic [1:0] kind;
        sent = 0;
        while (sent < item_total) begin
            phase_len  = $urandom_range(20, 120);
            push_pct   = $urandom_range(15, 90);
            quiet_mode = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) wait_drained();
            repeat (phase_len) begin
                r = $urandom_range(0, 99);
                if (r < 1)
                    kind = swlf_pkg::KIND_CLEAR;
                else if (r < 3)
                    kind = KIND_UNUSED;
                else if ($urandom_range(0, 99) < push_pct)
                    kind = swlf_pkg::KIND_PUSH;
                else
                    kind = swlf_pkg::KIND_POP;
                send_item(kind, pick_coord(), pick_coord());
                sent++;
            end
        end
        quiet_mode = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset once, run the tests, drain, report
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_points();
        test_full_window();
        test_drain_pause();
        test_random_walk(RANDOM_ITEMS);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (fit_errors == 0 && fit_wr == fit_rd) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
